[src/deadline_timer_queue_unit_macros.svh]
// assertion macros of the timer queue top level
`ifndef DEADLINE_TIMER_QUEUE_UNIT_MACROS_SVH
`define DEADLINE_TIMER_QUEUE_UNIT_MACROS_SVH

// plain property, sampled on clk_i, quiet while in reset
`define DTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define DTQ_ASSERT_IMP(lbl, ante, cons, msg) \
  `DTQ_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[src/dtq_pkg.sv]
// types and constants of the deadline timer queue
`timescale 1ns / 1ps

package dtq_pkg;

  // most expiries handed out by one tick
  localparam int unsigned MaxRes = 16;
  localparam int unsigned CntW   = 5;

  // operation codes, also used as result kinds
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_QUERY  = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [30:0] delay;
    logic [15:0] callback_id;
    logic [31:0] callback_arg;
    logic [3:0]  handle;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic        ok;
    logic [15:0] due_id;
    logic [31:0] due_arg;
    logic        last;
  } out_word_t;

  // one slot of the entry memory
  typedef struct packed {
    logic [31:0] deadline;
    logic [31:0] order;
    logic [15:0] cb_id;
    logic [31:0] cb_arg;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_EMIT,
    ST_FLUSH
  } state_e;

endpackage

[src/deadline_timer_queue_unit.sv]
// top level of the deadline timer queue: sequencer, scan compare and output register
`timescale 1ns / 1ps
`include "deadline_timer_queue_unit_macros.svh"

// add, cancel, query: one word in, one result word, placed in the output register once it is free
// tick: one scan of the entry memory per expiry plus a final one that finds nothing,
//   except at the cap of 16 expiries, where no final scan is made
// one input word at a time, a new one only after the last is through; in_stall_o is low only while idle
// reset clears all live flags, the millisecond counter and the insertion counter;
//   the entry memory is not cleared, only entries of live slots are used

module deadline_timer_queue_unit import dtq_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned AW = $clog2(SLOTS + 1);
  localparam logic [SW-1:0] LastIdx = SW'(SLOTS - 1);

  // sequencer and command
  state_e   state_q, state_d;
  in_word_t cmd_q, cmd_d;

  // time base and insertion numbering
  logic [31:0] now_q, now_d;
  logic [31:0] ins_cnt_q, ins_cnt_d;

  // scan of the entry memory
  logic [AW-1:0] scan_addr_q, scan_addr_d;
  logic          rd_pend_q, rd_pend_d;
  logic [SW-1:0] rd_idx_q, rd_idx_d;

  // earliest due entry seen so far in this scan
  logic          found_q, found_d;
  logic [SW-1:0] best_idx_q, best_idx_d;
  logic [31:0]   best_age_q, best_age_d;
  logic [31:0]   best_order_q, best_order_d;
  logic [15:0]   best_id_q, best_id_d;
  logic [31:0]   best_arg_q, best_arg_d;

  // expiry held back until we know whether it is the last one
  logic          pend_vld_q, pend_vld_d;
  out_word_t     pend_q, pend_d;
  logic [CntW-1:0] emit_cnt_q, emit_cnt_d;

  // output register
  logic      out_valid_q, out_valid_d;
  out_word_t out_q, out_d;
  logic      out_free;

  // memory and live flag hookup
  logic          mem_we, mem_re;
  entry_t        mem_wdata, mem_rdata;
  logic [SW-1:0] mem_raddr;
  logic          live_set, live_clr;
  logic [SW-1:0] live_clr_idx;
  logic [SLOTS-1:0] live_vec;
  logic          free_vld;
  logic [SW-1:0] free_idx;

  // handle lookup for cancel and query
  logic [SW-1:0] h_idx;
  logic          h_in_range;
  logic          h_live;

  // compare of the word just read against the best so far
  logic [31:0] age_c;
  logic [31:0] ord_diff_c;
  logic        earlier_c;
  logic        cand_c;

  dtq_mem #(
    .SLOTS (SLOTS),
    .SW    (SW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (free_idx),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  dtq_live #(
    .SLOTS (SLOTS),
    .SW    (SW)
  ) u_live (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .set_i      (live_set),
    .set_idx_i  (free_idx),
    .clr_i      (live_clr),
    .clr_idx_i  (live_clr_idx),
    .live_o     (live_vec),
    .free_o     (free_vld),
    .free_idx_o (free_idx)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign h_idx      = SW'(cmd_q.handle);
  assign h_in_range = (32'(cmd_q.handle) < SLOTS);
  assign h_live     = h_in_range ? live_vec[h_idx] : 1'b0;

  // new entry written on add
  assign mem_wdata.deadline = now_q + {1'b0, cmd_q.delay};
  assign mem_wdata.order    = ins_cnt_q;
  assign mem_wdata.cb_id    = cmd_q.callback_id;
  assign mem_wdata.cb_arg   = cmd_q.callback_arg;
  assign mem_raddr          = scan_addr_q[SW-1:0];

  // wrap-safe due test and ordering: larger age is earlier, ties by insertion number
  assign age_c      = now_q - mem_rdata.deadline;
  assign ord_diff_c = best_order_q - mem_rdata.order;
  assign earlier_c  = (age_c > best_age_q) || ((age_c == best_age_q) && !ord_diff_c[31]);
  assign cand_c     = rd_pend_q && live_vec[rd_idx_q] && !age_c[31]
                      && (!found_q || earlier_c);

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    now_d        = now_q;
    ins_cnt_d    = ins_cnt_q;
    scan_addr_d  = scan_addr_q;
    rd_pend_d    = 1'b0;
    rd_idx_d     = rd_idx_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_age_d   = best_age_q;
    best_order_d = best_order_q;
    best_id_d    = best_id_q;
    best_arg_d   = best_arg_q;
    pend_vld_d   = pend_vld_q;
    pend_d       = pend_q;
    emit_cnt_d   = emit_cnt_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    live_set     = 1'b0;
    live_clr     = 1'b0;
    live_clr_idx = best_idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d = in_word_i;
          if (in_word_i.operation == OP_TICK) begin
            now_d       = now_q + 32'd1;
            scan_addr_d = '0;
            found_d     = 1'b0;
            emit_cnt_d  = '0;
            pend_vld_d  = 1'b0;
            state_d     = ST_SCAN;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end

      ST_EXEC: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_d.kind    = cmd_q.operation;
          out_d.due_id  = '0;
          out_d.due_arg = '0;
          out_d.last    = 1'b1;
          if (cmd_q.operation == OP_ADD) begin
            // full queue answers slot 0, not accepted
            out_d.slot = free_vld ? 4'(free_idx) : 4'd0;
            out_d.ok   = free_vld;
            mem_we     = free_vld;
            live_set   = free_vld;
            if (free_vld) begin
              ins_cnt_d = ins_cnt_q + 32'd1;
            end
          end else begin
            out_d.slot   = cmd_q.handle;
            out_d.ok     = h_live;
            live_clr     = h_live && (cmd_q.operation == OP_CANCEL);
            live_clr_idx = h_idx;
          end
          state_d = ST_IDLE;
        end
      end

      ST_SCAN: begin
        mem_re    = (scan_addr_q < AW'(SLOTS));
        rd_pend_d = mem_re;
        rd_idx_d  = scan_addr_q[SW-1:0];
        if (mem_re) begin
          scan_addr_d = scan_addr_q + AW'(1);
        end
        if (cand_c) begin
          found_d      = 1'b1;
          best_idx_d   = rd_idx_q;
          best_age_d   = age_c;
          best_order_d = mem_rdata.order;
          best_id_d    = mem_rdata.cb_id;
          best_arg_d   = mem_rdata.cb_arg;
        end
        if (rd_pend_q && (rd_idx_q == LastIdx)) begin
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (found_q) begin
          if (!pend_vld_q || out_free) begin
            // earlier expiry now known not to be the last
            if (pend_vld_q) begin
              out_valid_d = 1'b1;
              out_d       = pend_q;
              out_d.last  = 1'b0;
            end
            pend_vld_d     = 1'b1;
            pend_d.kind    = OP_TICK;
            pend_d.slot    = 4'(best_idx_q);
            pend_d.ok      = 1'b1;
            pend_d.due_id  = best_id_q;
            pend_d.due_arg = best_arg_q;
            pend_d.last    = 1'b0;
            live_clr       = 1'b1;
            emit_cnt_d     = emit_cnt_q + CntW'(1);
            if (emit_cnt_q == CntW'(MaxRes - 1)) begin
              state_d = ST_FLUSH;
            end else begin
              scan_addr_d = '0;
              found_d     = 1'b0;
              state_d     = ST_SCAN;
            end
          end
        end else if (!pend_vld_q) begin
          // nothing due on this tick
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = pend_q;
          out_d.last  = 1'b1;
          pend_vld_d  = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      ST_FLUSH: begin
        // sixteen expiries reached, the rest waits for later ticks
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = pend_q;
          out_d.last  = 1'b1;
          pend_vld_d  = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      now_q       <= '0;
      ins_cnt_q   <= '0;
      scan_addr_q <= '0;
      rd_pend_q   <= 1'b0;
      found_q     <= 1'b0;
      pend_vld_q  <= 1'b0;
      emit_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      ins_cnt_q   <= ins_cnt_d;
      scan_addr_q <= scan_addr_d;
      rd_pend_q   <= rd_pend_d;
      found_q     <= found_d;
      pend_vld_q  <= pend_vld_d;
      emit_cnt_q  <= emit_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    rd_idx_q     <= rd_idx_d;
    best_idx_q   <= best_idx_d;
    best_age_q   <= best_age_d;
    best_order_q <= best_order_d;
    best_id_q    <= best_id_d;
    best_arg_q   <= best_arg_d;
    pend_q       <= pend_d;
    out_q        <= out_d;
  end

  `DTQ_ASSERT(a_emit_cap, emit_cnt_q <= CntW'(MaxRes), "more than sixteen expiries on one tick")
  `DTQ_ASSERT_IMP(a_idle_no_pend, state_q == ST_IDLE, !pend_vld_q, "expiry left behind in idle")
  `DTQ_ASSERT(a_live_one_op, !(live_set && live_clr), "slot set and cleared together")
  `DTQ_ASSERT_IMP(a_best_live, (state_q == ST_EMIT) && found_q, live_vec[best_idx_q], "chosen slot not live")

endmodule

[src/dtq_mem.sv]
// slot entry memory: one write port, one registered read port
`timescale 1ns / 1ps

module dtq_mem import dtq_pkg::*; #(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned SW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [SW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [SW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [SLOTS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/dtq_live.sv]
// live flags of the slots and lowest free slot search
`timescale 1ns / 1ps

module dtq_live import dtq_pkg::*; #(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned SW    = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             set_i,
  input  logic [SW-1:0]    set_idx_i,
  input  logic             clr_i,
  input  logic [SW-1:0]    clr_idx_i,
  output logic [SLOTS-1:0] live_o,
  output logic             free_o,
  output logic [SW-1:0]    free_idx_o
);

  logic [SLOTS-1:0] live_q;
  logic [SLOTS-1:0] live_d;

  always_comb begin
    live_d = live_q;
    if (set_i) begin
      live_d[set_idx_i] = 1'b1;
    end
    if (clr_i) begin
      live_d[clr_idx_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
    end else begin
      live_q <= live_d;
    end
  end

  // lowest free slot wins
  always_comb begin
    free_o     = 1'b0;
    free_idx_o = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!live_q[i]) begin
        free_o     = 1'b1;
        free_idx_o = SW'(i);
      end
    end
  end

  assign live_o = live_q;

endmodule

[test/tb_top.sv]
// self-checking testbench for the deadline timer queue unit
`timescale 1ns / 1ps

module tb_top;
  import dtq_pkg::*;

  localparam int Slots       = 16;
  localparam int CycleLimit  = 1000000;
  localparam int HoldCycles  = 500;
  localparam int SettleGap   = 40;   // a tick with nothing due still scans the whole entry memory
  localparam int TailCycles  = 400;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  // words still to be offered, and result words still owed by the block
  in_word_t  send_q [$];
  out_word_t owed_q [$];

  // idling control, set by the sequence below; hold_done and hold_left kept by the receiver
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  logic        in_took = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;
  out_word_t   owed_w;

  // shadow of the timer queue
  logic        tq_live [Slots];
  logic [31:0] tq_deadline [Slots];
  logic [31:0] tq_order [Slots];
  logic [15:0] tq_id [Slots];
  logic [31:0] tq_arg [Slots];
  logic [31:0] now_ms = '0;
  logic [31:0] insert_cnt = '0;

  initial begin
    for (int i = 0; i < Slots; i++) tq_live[i] = 1'b0;
  end

  deadline_timer_queue_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // one line per mismatch, and a count
  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_cnt, what, got, want);
    err_cnt++;
  endtask

  // timer queue behaviour for one accepted word; owed results go onto owed_q
  function automatic void apply_timer_op(input in_word_t w);
    out_word_t   batch [MaxRes];
    out_word_t   r;
    int          n;
    int          best;
    int          free_slot;
    logic [31:0] age;
    logic [31:0] best_age;
    logic        found;
    n = 0;
    r = '0;
    if (w.operation == OP_ADD) begin
      free_slot = -1;
      for (int s = Slots - 1; s >= 0; s--)
        if (!tq_live[s]) free_slot = s;
      r.kind = OP_ADD;
      if (free_slot >= 0) begin
        tq_live[free_slot]     = 1'b1;
        tq_deadline[free_slot] = now_ms + {1'b0, w.delay};
        tq_order[free_slot]    = insert_cnt;
        tq_id[free_slot]       = w.callback_id;
        tq_arg[free_slot]      = w.callback_arg;
        insert_cnt             = insert_cnt + 1;
        r.slot                 = 4'(free_slot);
        r.ok                   = 1'b1;
      end
      batch[0] = r;
      n = 1;
    end else if (w.operation == OP_CANCEL || w.operation == OP_QUERY) begin
      r.kind = w.operation;
      r.slot = w.handle;
      r.ok   = tq_live[w.handle];
      if (w.operation == OP_CANCEL) tq_live[w.handle] = 1'b0;
      batch[0] = r;
      n = 1;
    end else begin
      now_ms = now_ms + 1;
      found  = 1'b1;
      while (n < MaxRes && found) begin
        best     = -1;
        best_age = '0;
        // oldest due entry wins, ties go to the earlier insertion, both wrap-safe
        for (int s = 0; s < Slots; s++) begin
          age = now_ms - tq_deadline[s];
          if (tq_live[s] && age < 32'h8000_0000) begin
            if (best < 0 || age > best_age ||
                (age == best_age && (tq_order[best] - tq_order[s]) < 32'h8000_0000)) begin
              best     = s;
              best_age = age;
            end
          end
        end
        found = (best >= 0);
        if (found) begin
          tq_live[best] = 1'b0;
          r         = '0;
          r.kind    = OP_TICK;
          r.slot    = 4'(best);
          r.ok      = 1'b1;
          r.due_id  = tq_id[best];
          r.due_arg = tq_arg[best];
          batch[n]  = r;
          n++;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      r      = batch[i];
      r.last = (i == n - 1);
      owed_q.push_back(r);
    end
  endfunction

  function automatic void push_op(input op_e op, input logic [30:0] dly,
                                  input logic [15:0] id, input logic [31:0] arg,
                                  input logic [3:0] hdl);
    in_word_t w;
    w.operation    = op;
    w.delay        = dly;
    w.callback_id  = id;
    w.callback_arg = arg;
    w.handle       = hdl;
    send_q.push_back(w);
  endfunction

  // mostly short delays so entries expire often; now and then a huge one that sits
  function automatic in_word_t rand_word();
    in_word_t    w;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 35)      w.operation = OP_ADD;
    else if (pick < 50) w.operation = OP_CANCEL;
    else if (pick < 65) w.operation = OP_QUERY;
    else                w.operation = OP_TICK;
    pick = $urandom_range(9);
    if (pick == 0)     w.delay = 31'($urandom);
    else if (pick < 3) w.delay = 31'($urandom_range(20));
    else               w.delay = 31'($urandom_range(4));
    w.callback_id  = 16'($urandom);
    w.callback_arg = $urandom;
    w.handle       = 4'($urandom);
    return w;
  endfunction

  // wait until every word is taken and every owed result has come back
  task automatic drain();
    while (send_q.size() != 0 || in_valid || owed_q.size() != 0) @(posedge clk_i);
    repeat (SettleGap) @(posedge clk_i);
  endtask

  // driver: a new word only once the current one has gone, payload held while stalled
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_took)) begin
      if (send_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        in_word  <= send_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off counted here
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor: predict on input handshakes, check on output handshakes
  always @(posedge clk_i) begin
    in_took <= in_valid && !in_stall;
    if (rst_ni) begin
      if (in_valid && !in_stall) apply_timer_op(in_word);
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          flag_mismatch("result word with nothing owed", 64'(out_word), '0);
        end else begin
          owed_w = owed_q.pop_front();
          if (out_word.kind !== owed_w.kind)
            flag_mismatch("kind", 64'(out_word.kind), 64'(owed_w.kind));
          if (out_word.slot !== owed_w.slot)
            flag_mismatch("slot", 64'(out_word.slot), 64'(owed_w.slot));
          if (out_word.ok !== owed_w.ok)
            flag_mismatch("ok", 64'(out_word.ok), 64'(owed_w.ok));
          if (out_word.due_id !== owed_w.due_id)
            flag_mismatch("due_id", 64'(out_word.due_id), 64'(owed_w.due_id));
          if (out_word.due_arg !== owed_w.due_arg)
            flag_mismatch("due_arg", 64'(out_word.due_arg), 64'(owed_w.due_arg));
          if (out_word.last !== owed_w.last)
            flag_mismatch("last", 64'(out_word.last), 64'(owed_w.last));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int ph;
    repeat (6) @(posedge clk_i);
    #1 rst_ni = 1'b1;

    // directed part
    push_op(OP_TICK, '0, '0, '0, '0);                      // tick on an empty queue
    push_op(OP_QUERY, '0, '0, '0, 4'h0);                   // query of a free slot
    push_op(OP_CANCEL, '0, '0, '0, 4'hf);                  // cancel of a free slot
    push_op(OP_ADD, 31'h7fff_ffff, 16'hffff, 32'hffff_ffff, 4'hf);
    // odd slots get delay 0 and expire first, even slots delay 1, same deadline in insertion order
    for (int i = 1; i < Slots; i++)
      push_op(OP_ADD, {30'd0, ~i[0]}, 16'(i * 16'h1111), {16'(i), 16'(~i)}, 4'(i));
    push_op(OP_ADD, 31'd5, 16'h1234, 32'h5555_aaaa, 4'h0); // queue full
    push_op(OP_QUERY, '0, '0, '0, 4'h0);                   // query of a live slot
    push_op(OP_CANCEL, '0, '0, '0, 4'h0);                  // cancel frees the far deadline
    push_op(OP_ADD, '0, '0, '0, '0);                       // zero delay, lands in slot 0
    push_op(OP_TICK, '0, '0, '0, '0);                      // all sixteen expire at once
    push_op(OP_TICK, '0, '0, '0, '0);                      // nothing left due
    drain();

    // random part, one idling pattern per phase
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 88; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 88; end
        default: begin gap_pct = 35; stall_pct = 35; end
      endcase
      repeat (34) send_q.push_back(rand_word());
      drain();
    end

    // back-pressure: receiver holds off while the sender keeps offering
    gap_pct   = 0;
    stall_pct = 0;
    repeat (20) send_q.push_back(rand_word());
    @(posedge clk_i);
    hold_req = 1'b1;
    drain();

    repeat (TailCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
